FILE: hdl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants, microcode table and quarter-round helper for the
// ChaCha20 stream XOR block.
// ----------------------------------------------------------------------------
`default_nettype none

package cc20_pkg;

    localparam int WORD_W          = 32;
    localparam int STATE_WORDS     = 16;
    localparam int POS_W           = 4;
    localparam int CNT_W           = 3;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int ROUND_COUNT_DEF = 20;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START = 3'd6;

    // "expand 32-byte k" / "expand 16-byte k"
    localparam logic [WORD_W-1:0] SIGMA_0    = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA_1_32 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA_1_16 = 32'h3120_646e;
    localparam logic [WORD_W-1:0] SIGMA_2_32 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA_2_16 = 32'h7962_2d36;
    localparam logic [WORD_W-1:0] SIGMA_3    = 32'h6b20_6574;

    localparam logic [CNT_W-1:0] FULL_COUNT = 3'd4;

    typedef logic [2:0] t_pc;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_LOAD,
        UOP_HALF_A,
        UOP_HALF_B,
        UOP_FINAL,
        UOP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_READY,
        C_MORE_ROUNDS,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Sequencer -> datapath
    typedef struct packed {
        t_uop op;
        logic go;
        logic diag;
    } t_ctrl;

    // Datapath / ports -> sequencer
    typedef struct packed {
        logic in_valid;
        logic ready;
        logic out_busy;
    } t_status;

    typedef struct packed {
        logic [CFG_W-1:0] key0;
        logic [CFG_W-1:0] key1;
        logic [CFG_W-1:0] key2;
        logic [CFG_W-1:0] key3;
        logic             long_key;
        logic [CFG_W-1:0] nonce;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } t_quad;

    // Program steps
    localparam t_pc PC_WAIT   = 3'd0;
    localparam t_pc PC_CHECK  = 3'd1;
    localparam t_pc PC_LOAD   = 3'd2;
    localparam t_pc PC_HALF_A = 3'd3;
    localparam t_pc PC_HALF_B = 3'd4;
    localparam t_pc PC_FINAL  = 3'd5;
    localparam t_pc PC_EMIT   = 3'd6;
    localparam t_pc PC_LAST   = PC_EMIT;

    // Fall-through goes to pc+1, and from the last step back to PC_WAIT.
    function automatic t_uword ucode_rom(t_pc pc);
        t_uword w;
        w = '{op: UOP_NOP, cond: C_ALWAYS, target: PC_WAIT};
        unique case (pc)
            PC_WAIT:   w = '{op: UOP_ACCEPT, cond: C_NO_ITEM,     target: PC_WAIT};
            PC_CHECK:  w = '{op: UOP_NOP,    cond: C_READY,       target: PC_EMIT};
            PC_LOAD:   w = '{op: UOP_LOAD,   cond: C_NEVER,       target: PC_WAIT};
            PC_HALF_A: w = '{op: UOP_HALF_A, cond: C_NEVER,       target: PC_WAIT};
            PC_HALF_B: w = '{op: UOP_HALF_B, cond: C_MORE_ROUNDS, target: PC_HALF_A};
            PC_FINAL:  w = '{op: UOP_FINAL,  cond: C_NEVER,       target: PC_WAIT};
            PC_EMIT:   w = '{op: UOP_EMIT,   cond: C_OUT_BUSY,    target: PC_EMIT};
            default:   w = '{op: UOP_NOP,    cond: C_ALWAYS,      target: PC_WAIT};
        endcase
        return w;
    endfunction

    // First half of a quarter round (rotations 16, 12) or second (8, 7)
    function automatic t_quad qr_half(t_quad q, logic second);
        t_quad             r;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        r   = q;
        r.a = q.a + q.b;
        x   = q.d ^ r.a;
        r.d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
        r.c = q.c + r.d;
        y   = q.b ^ r.c;
        r.b = second ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cc20_ucode.sv
// ----------------------------------------------------------------------------
// cc20_ucode
// Step counter, microcode table lookup, conditional jumps and round counter.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_ucode import cc20_pkg::*; #(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_status i_status,
    output t_ctrl        o_ctrl
);

    localparam int RW = $clog2(ROUND_COUNT + 1);

    t_pc           r_pc,    n_pc;
    logic [RW-1:0] r_round, n_round;
    t_uword        uw;
    logic          taken;
    logic          go;

    always_comb begin
        uw = ucode_rom(r_pc);

        unique case (uw.cond)
            C_NEVER:       taken = 1'b0;
            C_ALWAYS:      taken = 1'b1;
            C_NO_ITEM:     taken = !i_status.in_valid;
            C_READY:       taken = i_status.ready;
            C_MORE_ROUNDS: taken = (r_round + RW'(1)) != RW'(ROUND_COUNT);
            C_OUT_BUSY:    taken = i_status.out_busy;
            default:       taken = 1'b0;
        endcase

        unique case (uw.op)
            UOP_ACCEPT: go = i_status.in_valid;
            UOP_EMIT:   go = !i_status.out_busy;
            default:    go = 1'b1;
        endcase

        if (taken) begin
            n_pc = uw.target;
        end else if (r_pc == PC_LAST) begin
            n_pc = PC_WAIT;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end

        n_round = r_round;
        if (uw.op == UOP_LOAD) begin
            n_round = '0;
        end else if (uw.op == UOP_HALF_B) begin
            n_round = r_round + RW'(1);
        end

        o_ctrl.op   = uw.op;
        o_ctrl.go   = go;
        o_ctrl.diag = r_round[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_WAIT;
            r_round <= '0;
        end else begin
            r_pc    <= n_pc;
            r_round <= n_round;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cc20_core.sv
// ----------------------------------------------------------------------------
// cc20_core
// Working state, four quarter-round lanes, input state build, final add,
// block counter and keystream word position.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_core import cc20_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctrl             i_ctrl,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_cfg_load,
    input  wire logic [CFG_W-1:0]  i_cfg_counter,
    input  wire logic              i_ends,
    output logic [WORD_W-1:0]      o_ks,
    output logic                   o_ready
);

    logic [WORD_W-1:0] r_w [STATE_WORDS];
    logic [WORD_W-1:0] n_w [STATE_WORDS];
    logic [WORD_W-1:0] init [STATE_WORDS];
    logic [CFG_W-1:0]  r_ctr, n_ctr;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_ready, n_ready;

    always_comb begin
        init[0]  = SIGMA_0;
        init[1]  = i_cfg.long_key ? SIGMA_1_32 : SIGMA_1_16;
        init[2]  = i_cfg.long_key ? SIGMA_2_32 : SIGMA_2_16;
        init[3]  = SIGMA_3;
        init[4]  = i_cfg.key0[31:0];
        init[5]  = i_cfg.key0[63:32];
        init[6]  = i_cfg.key1[31:0];
        init[7]  = i_cfg.key1[63:32];
        // short key: bytes 0..15 repeat
        init[8]  = i_cfg.long_key ? i_cfg.key2[31:0]  : i_cfg.key0[31:0];
        init[9]  = i_cfg.long_key ? i_cfg.key2[63:32] : i_cfg.key0[63:32];
        init[10] = i_cfg.long_key ? i_cfg.key3[31:0]  : i_cfg.key1[31:0];
        init[11] = i_cfg.long_key ? i_cfg.key3[63:32] : i_cfg.key1[63:32];
        init[12] = r_ctr[31:0];
        init[13] = r_ctr[63:32];
        init[14] = i_cfg.nonce[31:0];
        init[15] = i_cfg.nonce[63:32];
    end

    always_comb begin
        t_quad      q;
        t_quad      qo;
        logic [3:0] ia;
        logic [3:0] ib;
        logic [3:0] ic;
        logic [3:0] id;

        q       = '0;
        qo      = '0;
        ia      = '0;
        ib      = '0;
        ic      = '0;
        id      = '0;
        n_w     = r_w;
        n_ctr   = r_ctr;
        n_pos   = r_pos;
        n_ready = r_ready;

        unique case (i_ctrl.op)
            UOP_LOAD: begin
                n_w = init;
            end
            UOP_HALF_A, UOP_HALF_B: begin
                for (int j = 0; j < 4; j++) begin
                    ia = 4'(j);
                    ib = i_ctrl.diag ? 4'(4 + ((j + 1) & 3))  : 4'(4 + j);
                    ic = i_ctrl.diag ? 4'(8 + ((j + 2) & 3))  : 4'(8 + j);
                    id = i_ctrl.diag ? 4'(12 + ((j + 3) & 3)) : 4'(12 + j);
                    q  = '{a: r_w[ia], b: r_w[ib], c: r_w[ic], d: r_w[id]};
                    qo = qr_half(q, i_ctrl.op == UOP_HALF_B);
                    n_w[ia] = qo.a;
                    n_w[ib] = qo.b;
                    n_w[ic] = qo.c;
                    n_w[id] = qo.d;
                end
            end
            UOP_FINAL: begin
                for (int i = 0; i < STATE_WORDS; i++) begin
                    n_w[i] = r_w[i] + init[i];
                end
                n_ctr   = r_ctr + CFG_W'(1);
                n_ready = 1'b1;
                n_pos   = '0;
            end
            UOP_EMIT: begin
                if (i_ctrl.go) begin
                    n_pos = r_pos + POS_W'(1);
                    if (r_pos == '1 || i_ends) begin
                        n_ready = 1'b0;
                        n_pos   = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        if (i_cfg_load) begin
            n_ctr   = i_cfg_counter;
            n_ready = 1'b0;
            n_pos   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr   <= '0;
            r_pos   <= '0;
            r_ready <= 1'b0;
        end else begin
            r_ctr   <= n_ctr;
            r_pos   <= n_pos;
            r_ready <= n_ready;
        end
    end

    assign o_ks    = r_w[r_pos];
    assign o_ready = r_ready;

endmodule

`default_nettype wire

FILE: hdl/chacha20_stream_xor.sv
// ----------------------------------------------------------------------------
// chacha20_stream_xor
// ChaCha20 (64-bit nonce, 64-bit counter) keystream XOR, one 32-bit word per
// transaction, driven by a microcoded sequencer over a quarter-round datapath.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_text_word,            | sink
//          | i_byte_count, i_end_of_message                  |
//  out     | o_out_valid, i_out_stall, o_cipher_word,        | source
//          | o_valid_out, o_final_word                       |
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data               | write only
//
//  A word with keystream held passes the accept, check and emit steps.
//  A word that starts a block also passes load, the half-round steps and final
//  add: one sequencer step per half quarter-round, four lanes in parallel.
//  Synchronous active-low reset; no memory clearing pass.
//  Output stall holds the result register; the sequencer waits in its emit step.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_stream_xor import cc20_pkg::*; #(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [WORD_W-1:0]    i_text_word,
    input  wire logic [CNT_W-1:0]     i_byte_count,
    input  wire logic                 i_end_of_message,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [WORD_W-1:0]         o_cipher_word,
    output logic [CNT_W-1:0]          o_valid_out,
    output logic                      o_final_word
);

    t_cfg              r_cfg;
    logic [CFG_W-1:0]  r_start;
    logic [CFG_W-1:0]  cfg_counter;
    logic              cfg_load;

    logic [WORD_W-1:0] r_text;
    logic [CNT_W-1:0]  r_count;
    logic              r_ends;
    logic [CNT_W-1:0]  eff_count;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_cipher;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_final;

    t_ctrl             ctrl;
    t_status           status;
    logic [WORD_W-1:0] ks;
    logic              ready;
    logic              out_busy;
    logic              accept;
    logic              emit;
    logic [WORD_W-1:0] mask;

    // ---------------- configuration ----------------
    assign cfg_load    = i_cfg_we && (i_cfg_index <= REG_START);
    assign cfg_counter = (i_cfg_index == REG_START) ? i_cfg_data : r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key0     <= '0;
            r_cfg.key1     <= '0;
            r_cfg.key2     <= '0;
            r_cfg.key3     <= '0;
            r_cfg.long_key <= 1'b1;
            r_cfg.nonce    <= '0;
            r_start        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY0:  r_cfg.key0     <= i_cfg_data;
                REG_KEY1:  r_cfg.key1     <= i_cfg_data;
                REG_KEY2:  r_cfg.key2     <= i_cfg_data;
                REG_KEY3:  r_cfg.key3     <= i_cfg_data;
                REG_LONG:  r_cfg.long_key <= i_cfg_data[0];
                REG_NONCE: r_cfg.nonce    <= i_cfg_data;
                REG_START: r_start        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------- input hold ----------------
    assign o_in_stall = (ctrl.op != UOP_ACCEPT);
    assign accept     = i_in_valid && !o_in_stall;
    assign eff_count  = (i_byte_count == '0 || i_byte_count > FULL_COUNT)
                        ? FULL_COUNT : i_byte_count;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_text  <= i_text_word;
            r_count <= eff_count;
            r_ends  <= i_end_of_message || (eff_count != FULL_COUNT);
        end
    end

    // ---------------- sequencer and datapath ----------------
    assign out_busy = r_out_valid && i_out_stall;
    assign status   = '{in_valid: i_in_valid, ready: ready, out_busy: out_busy};

    cc20_ucode #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_ucode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    cc20_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_cfg         (r_cfg),
        .i_cfg_load    (cfg_load),
        .i_cfg_counter (cfg_counter),
        .i_ends        (r_ends),
        .o_ks          (ks),
        .o_ready       (ready)
    );

    // ---------------- result register ----------------
    assign emit = (ctrl.op == UOP_EMIT) && ctrl.go;

    always_comb begin
        case (r_count)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_cipher    <= (r_text ^ ks) & mask;
            r_out_count <= r_count;
            r_final     <= r_ends;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cipher_word = r_cipher;
    assign o_valid_out   = r_out_count;
    assign o_final_word  = r_final;

endmodule

`default_nettype wire

FILE: hdl/cc20_checker.sv
// ----------------------------------------------------------------------------
// cc20_checker
// Port-level checks for the ChaCha20 stream XOR block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_cipher_word,
    input wire logic [2:0]  o_valid_out,
    input wire logic        o_final_word
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cipher_word)
            && $stable(o_valid_out) && $stable(o_final_word))
        else $error("stalled result changed");

    // byte count in range; a short word always ends the message
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_valid_out == 3'd4)
            || ((o_valid_out == 3'd1 || o_valid_out == 3'd2 || o_valid_out == 3'd3)
                && o_final_word))
        else $error("bad byte count or missing final flag");

    // bytes past the count are zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_valid_out != 3'd1 || o_cipher_word[31:8] == 24'd0)
            && (o_valid_out != 3'd2 || o_cipher_word[31:16] == 16'd0)
            && (o_valid_out != 3'd3 || o_cipher_word[31:24] == 8'd0))
        else $error("invalid bytes not cleared");

    // one word in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken in back-to-back cycles");

endmodule

bind chacha20_stream_xor cc20_checker u_cc20_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_cipher_word (o_cipher_word),
    .o_valid_out   (o_valid_out),
    .o_final_word  (o_final_word)
);

`default_nettype wire
